@@ hw/rtl/esm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esm_pkg
// Shared widths, codes and control structs of the encoder speed meter.
// ----------------------------------------------------------------------------
package esm_pkg;

	localparam int CNT_W   = 16;
	localparam int PER_W   = 32;
	localparam int POS_W   = 32;
	localparam int SPD_W   = 32;
	localparam int THR_W   = 31;
	localparam int MSC_W   = 20;
	localparam int NUM_W   = 32;
	localparam int PROD_W  = CNT_W + MSC_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int ITER_W  = 5;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 72;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [ITER_W-1:0] MUL_LAST = ITER_W'(CNT_W - 1);
	localparam logic [ITER_W-1:0] DIV_LAST = ITER_W'(NUM_W - 1);

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_M_SCALE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_T_NUMER   = 2'd2;

	localparam logic [THR_W-1:0] THR_RESET = 31'd819200;
	localparam logic [MSC_W-1:0] MSC_RESET = 20'd4000;
	localparam logic [NUM_W-1:0] NUM_RESET = 32'd336000000;

	localparam logic [SPD_W-1:0] SPD_MAX = 32'h7FFF_FFFF;

	localparam logic METHOD_M = 1'b0;
	localparam logic METHOD_T = 1'b1;

	typedef struct packed {
		logic start;
		logic op_div;
	} esm_alu_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} esm_alu_sts_t;

endpackage

@@ hw/rtl/esm_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esm_alu
// Iterative shift-add multiplier and restoring divider on one shared adder.
// ----------------------------------------------------------------------------
module esm_alu (
	input  logic                              clk,
	input  logic                              arst_n,
	input  esm_pkg::esm_alu_cmd_t             cmd,
	input  logic [esm_pkg::NUM_W-1:0]         dividend,
	input  logic [esm_pkg::PER_W-1:0]         divisor,
	input  logic [esm_pkg::MSC_W-1:0]         mscale,
	input  logic [esm_pkg::CNT_W-1:0]         mplier,
	output esm_pkg::esm_alu_sts_t             sts,
	output logic [esm_pkg::PROD_W-1:0]        result
);

	logic                          busy_q;
	logic                          done_q;
	logic                          op_div_q;
	logic [esm_pkg::ITER_W-1:0]    cnt_q;
	logic [esm_pkg::ACC_W-1:0]     acc_q;
	logic [esm_pkg::NUM_W-1:0]     quo_q;
	logic [esm_pkg::PER_W-1:0]     divisor_q;
	logic [esm_pkg::MSC_W-1:0]     mscale_q;

	logic [esm_pkg::NUM_W:0]       rem_sh;
	logic [esm_pkg::ACC_W-1:0]     op_a;
	logic [esm_pkg::ACC_W-1:0]     op_b;
	logic [esm_pkg::ACC_W-1:0]     sum;

	// dividend bits and multiplier bits both leave quo_q from the top
	assign rem_sh = {acc_q[esm_pkg::NUM_W-1:0], quo_q[esm_pkg::NUM_W-1]};

	always_comb begin
		if (op_div_q) begin
			op_a = {{(esm_pkg::ACC_W - esm_pkg::NUM_W - 1){1'b0}}, rem_sh};
			op_b = ~{{(esm_pkg::ACC_W - esm_pkg::PER_W){1'b0}}, divisor_q};
		end else begin
			op_a = {acc_q[esm_pkg::ACC_W-2:0], 1'b0};
			op_b = quo_q[esm_pkg::NUM_W-1] ?
				{{(esm_pkg::ACC_W - esm_pkg::MSC_W){1'b0}}, mscale_q} : '0;
		end
	end

	assign sum = op_a + op_b + {{(esm_pkg::ACC_W-1){1'b0}}, op_div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && cnt_q == '0) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_div_q  <= cmd.op_div;
			cnt_q     <= cmd.op_div ? esm_pkg::DIV_LAST : esm_pkg::MUL_LAST;
			acc_q     <= '0;
			quo_q     <= cmd.op_div ? dividend :
				{mplier, {(esm_pkg::NUM_W - esm_pkg::CNT_W){1'b0}}};
			divisor_q <= divisor;
			mscale_q  <= mscale;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (op_div_q) begin
				// negative difference: keep the shifted remainder
				acc_q <= sum[esm_pkg::ACC_W-1] ?
					{{(esm_pkg::ACC_W - esm_pkg::NUM_W - 1){1'b0}}, rem_sh} : sum;
				quo_q <= {quo_q[esm_pkg::NUM_W-2:0], ~sum[esm_pkg::ACC_W-1]};
			end else begin
				acc_q <= sum;
				quo_q <= {quo_q[esm_pkg::NUM_W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = op_div_q ?
		{{(esm_pkg::PROD_W - esm_pkg::NUM_W){1'b0}}, quo_q} : acc_q[esm_pkg::PROD_W-1:0];

endmodule

@@ hw/rtl/encoder_mt_speed_meter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_mt_speed_meter
// Quadrature position and M/T speed measurement with automatic switching.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample tick: the encoder counter reading and the latest
//   captured pulse period. m_* returns one result per tick: position, signed
//   Q16.16 speed and direction in tdata, the method used in tuser.
//   cfg_* writes the switch threshold, M scale and T numerator; write only
//   while no tick is in flight. cfg_ready is always high.
// Timing:
//   a tick is taken only while the block is idle. One shared adder runs a
//   shift-add multiply (16 steps) in M mode or a restoring divide (32 steps)
//   in T mode, and the next tick is taken only once the result has moved
//   into the output register.
// Reset and stalls:
//   reset clears position, last counter, last speed and selects M mode;
//   registers go to their defaults. A stalled result holds in the output
//   register and the finished computation waits behind it.
// ----------------------------------------------------------------------------
module encoder_mt_speed_meter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// counter_value[15:0], pulse_period[47:16]
	input  logic [esm_pkg::IN_TDATA_W-1:0]        s_tdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// position[31:0], speed[63:32], direction[64], zero fill
	output logic [esm_pkg::OUT_TDATA_W-1:0]       m_tdata,
	// method[0]
	output logic                                  m_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [esm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [esm_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                          state_q;
	logic [esm_pkg::THR_W-1:0]     thr_q;
	logic [esm_pkg::MSC_W-1:0]     msc_q;
	logic [esm_pkg::NUM_W-1:0]     num_q;
	logic [esm_pkg::CNT_W-1:0]     last_cnt_q;
	logic [esm_pkg::POS_W-1:0]     pos_acc_q;
	logic [esm_pkg::SPD_W-1:0]     last_spd_q;
	logic                          method_q;
	logic                          neg_q;

	logic                          out_valid_q;
	logic [esm_pkg::POS_W-1:0]     out_pos_q;
	logic [esm_pkg::SPD_W-1:0]     out_spd_q;
	logic                          out_dir_q;
	logic                          out_method_q;

	logic [esm_pkg::CNT_W-1:0]     cv;
	logic [esm_pkg::PER_W-1:0]     period;
	logic [esm_pkg::CNT_W-1:0]     d16;
	logic                          neg;
	logic [esm_pkg::CNT_W-1:0]     dmag;
	logic [esm_pkg::POS_W-1:0]     dext;
	logic [esm_pkg::SPD_W-1:0]     prev_mag;
	logic [esm_pkg::SPD_W-1:0]     thr_ext;
	logic                          use_t;
	logic                          in_xfer;
	logic                          out_free;
	logic                          finish;

	esm_pkg::esm_alu_cmd_t         alu_cmd;
	esm_pkg::esm_alu_sts_t         alu_sts;
	logic [esm_pkg::PROD_W-1:0]    alu_res;
	logic [esm_pkg::SPD_W-1:0]     sat_mag;

	assign cv     = s_tdata[esm_pkg::CNT_W-1:0];
	assign period = s_tdata[esm_pkg::CNT_W +: esm_pkg::PER_W];

	assign d16      = cv - last_cnt_q;
	assign neg      = d16[esm_pkg::CNT_W-1];
	assign dmag     = neg ? (~d16 + 1'b1) : d16;
	assign dext     = {{(esm_pkg::POS_W - esm_pkg::CNT_W){neg}}, d16};
	assign prev_mag = last_spd_q[esm_pkg::SPD_W-1] ? (~last_spd_q + 1'b1) : last_spd_q;
	assign thr_ext  = {1'b0, thr_q};

	always_comb begin
		if (method_q == esm_pkg::METHOD_M) begin
			use_t = (prev_mag < thr_ext) && (period != '0);
		end else begin
			use_t = !((prev_mag > thr_ext) || (period == '0));
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign finish   = (state_q == ST_RUN) && alu_sts.done && out_free;

	assign alu_cmd.start  = in_xfer;
	assign alu_cmd.op_div = use_t;

	esm_alu u_alu (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (alu_cmd),
		.dividend (num_q),
		.divisor  (period),
		.mscale   (msc_q),
		.mplier   (dmag),
		.sts      (alu_sts),
		.result   (alu_res)
	);

	// clamp to the largest positive Q16.16 value before the sign goes on
	assign sat_mag = (|alu_res[esm_pkg::PROD_W-1:esm_pkg::SPD_W-1]) ?
		esm_pkg::SPD_MAX : {1'b0, alu_res[esm_pkg::SPD_W-2:0]};

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= esm_pkg::THR_RESET;
			msc_q <= esm_pkg::MSC_RESET;
			num_q <= esm_pkg::NUM_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				esm_pkg::REG_THRESHOLD: thr_q <= cfg_data[esm_pkg::THR_W-1:0];
				esm_pkg::REG_M_SCALE:   msc_q <= cfg_data[esm_pkg::MSC_W-1:0];
				esm_pkg::REG_T_NUMER:   num_q <= cfg_data[esm_pkg::NUM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			last_cnt_q <= '0;
			pos_acc_q  <= '0;
			last_spd_q <= '0;
			method_q   <= esm_pkg::METHOD_M;
			neg_q      <= 1'b0;
		end else begin
			if (in_xfer) begin
				state_q    <= ST_RUN;
				last_cnt_q <= cv;
				pos_acc_q  <= pos_acc_q + dext;
				method_q   <= use_t;
				neg_q      <= neg;
			end else if (finish) begin
				state_q    <= ST_IDLE;
				last_spd_q <= neg_q ? (~sat_mag + 1'b1) : sat_mag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_pos_q    <= pos_acc_q;
			out_spd_q    <= neg_q ? (~sat_mag + 1'b1) : sat_mag;
			out_dir_q    <= ~neg_q;
			out_method_q <= method_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_method_q;
	assign m_tdata  = {{(esm_pkg::OUT_TDATA_W - esm_pkg::POS_W - esm_pkg::SPD_W - 1){1'b0}},
		out_dir_q, out_spd_q, out_pos_q};

`ifndef SYNTH
	// a transfer always launches the shared unit
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> alu_sts.busy)
		else $error("shared unit not started after input transfer");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(alu_sts.busy && alu_sts.done))
		else $error("shared unit busy and done at once");

	// no input is taken while a tick is still being computed
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		alu_sts.busy |-> !s_tready)
		else $error("input ready while computation in flight");

	a_speed_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[63:32] != 32'h8000_0000)
		else $error("speed magnitude escaped saturation");
`endif

endmodule
